FILE: rtl/imhq_pkg.sv
package imhq_pkg;

  localparam int CAPACITY   = 256;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PRIO_W     = 32;
  localparam int PAY_W      = 32;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int HANDLE_W   = 8;

  // The free-slot search looks at one group of live bits per cycle.
  localparam int SCAN_GW     = 16;
  localparam int SCAN_GROUPS = CAPACITY / SCAN_GW;
  localparam int SCAN_SEL_W  = $clog2(SCAN_GROUPS);
  localparam int SCAN_OFF_W  = $clog2(SCAN_GW);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_UPDATE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DEAD  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SCAN,
    S_UP_CHK,
    S_UP_SLOT,
    S_UP_CMP,
    S_PLACE,
    S_EX_ROOT,
    S_EX_DATA,
    S_EX_LAST,
    S_EX_LPRIO,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_LCMP,
    S_DN_RCMP,
    S_DN_MOVE,
    S_UD_READ,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             set_en;
    logic [IDX_W-1:0] set_slot;
    logic             clr_en;
    logic [IDX_W-1:0] clr_slot;
    logic [IDX_W-1:0] query_slot;
  } scan_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] slot;
    logic             query_live;
  } scan_stat_t;

endpackage

FILE: rtl/imhq_in_if.sv
interface imhq_in_if;
  import imhq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PAY_W-1:0]    payload;
  logic [PRIO_W-1:0]   priority_req;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, kind, payload, priority_req, handle, input ready);
  modport sink   (input valid, kind, payload, priority_req, handle, output ready);
endinterface

FILE: rtl/imhq_out_if.sv
interface imhq_out_if;
  import imhq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] result_handle;
  logic [PAY_W-1:0]    result_payload;
  logic [PRIO_W-1:0]   result_priority;

  modport source (output valid, status, result_handle, result_payload, result_priority,
                  input ready);
  modport sink   (input valid, status, result_handle, result_payload, result_priority,
                  output ready);
endinterface

FILE: rtl/imhq_free_scan.sv
module imhq_free_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imhq_pkg::scan_ctrl_t ctrl,
  output imhq_pkg::scan_stat_t stat
);
  import imhq_pkg::*;

  logic [CAPACITY-1:0]   live_r;
  logic                  busy_r;
  logic [SCAN_SEL_W-1:0] grp_r;
  logic [SCAN_GW-1:0]    grp_bits;
  logic                  found;
  logic [SCAN_OFF_W-1:0] offset;

  assign grp_bits = live_r[grp_r*SCAN_GW +: SCAN_GW];

  // Lowest clear bit of the current group.
  always_comb begin
    found  = 1'b0;
    offset = '0;
    for (int i = SCAN_GW - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        found  = 1'b1;
        offset = SCAN_OFF_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      busy_r <= 1'b0;
      grp_r  <= '0;
    end else begin
      if (ctrl.set_en) live_r[ctrl.set_slot] <= 1'b1;
      if (ctrl.clr_en) live_r[ctrl.clr_slot] <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        grp_r  <= '0;
      end else if (busy_r) begin
        if (found) busy_r <= 1'b0;
        else       grp_r  <= grp_r + 1'b1;
      end
    end
  end

  assign stat.busy       = busy_r;
  assign stat.done       = busy_r && found;
  assign stat.slot       = {grp_r, offset};
  assign stat.query_live = live_r[ctrl.query_slot];
endmodule

FILE: rtl/indexed_min_heap_queue_core.sv
// Indexed binary min-heap of 256 entries with stable handles. Each request is
// an insert, an extract-minimum or a priority update, and each gives exactly
// one result; the block takes one request at a time and is not ready again
// until its result has been taken. An insert first searches the live bits for
// the lowest free slot, sixteen slots a cycle, then sifts up a level at a
// time: a check, a read of the parent's slot, a compare. An extract reads the
// root, its data and the last entry, then sifts down: a check, reads of the
// children, a compare with each child and the move. An update reads the old
// priority and position, then sifts one way or the other, or ends at once if
// the priority is unchanged. The pace is set by the single read port on each
// of the slot and heap-order memories and by the one shared priority comparator.
module indexed_min_heap_queue_core (
  input logic       clk,
  input logic       rst_n,
  imhq_in_if.sink   in_req,
  imhq_out_if.source out_res
);
  import imhq_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  kind_t               kind_r;
  logic [PAY_W-1:0]    pay_r;
  logic [PRIO_W-1:0]   q_r, q_nxt;       // priority of the entry being sifted
  logic [HANDLE_W-1:0] h_r;
  logic [IDX_W-1:0]    p_r, p_nxt;       // current hole position
  logic [IDX_W-1:0]    s_r, s_nxt;       // slot of the entry being sifted
  logic [IDX_W-1:0]    ps_r, ps_nxt;     // parent or left-child slot
  logic [IDX_W-1:0]    rs_r, rs_nxt;     // right-child slot
  logic                bsel_r, bsel_nxt;
  logic [IDX_W-1:0]    bidx_r, bidx_nxt;
  logic [IDX_W-1:0]    bslot_r, bslot_nxt;
  logic [PRIO_W-1:0]   bprio_r, bprio_nxt;

  status_t             res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_handle_r, res_handle_nxt;
  logic [PAY_W-1:0]    res_pay_r, res_pay_nxt;
  logic [PRIO_W-1:0]   res_prio_r, res_prio_nxt;

  // Memories: heap order, slot priority, slot payload, slot position.
  logic [IDX_W-1:0]  ho_mem  [CAPACITY];
  logic [PRIO_W-1:0] pr_mem  [CAPACITY];
  logic [PAY_W-1:0]  pl_mem  [CAPACITY];
  logic [IDX_W-1:0]  pos_mem [CAPACITY];

  logic              ho_we, pr_we, pl_we, pos_we;
  logic [IDX_W-1:0]  ho_wa, pr_wa, pl_wa, pos_wa;
  logic [IDX_W-1:0]  ho_wd, pos_wd;
  logic [PRIO_W-1:0] pr_wd;
  logic [IDX_W-1:0]  ho_ra, pr_ra, pl_ra, pos_ra;
  logic [IDX_W-1:0]  ho_q, pos_q;
  logic [PRIO_W-1:0] pr_q;
  logic [PAY_W-1:0]  pl_q;

  always_ff @(posedge clk) begin
    if (ho_we)  ho_mem[ho_wa]   <= ho_wd;
    if (pr_we)  pr_mem[pr_wa]   <= pr_wd;
    if (pl_we)  pl_mem[pl_wa]   <= pay_r;
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    ho_q  <= ho_mem[ho_ra];
    pr_q  <= pr_mem[pr_ra];
    pl_q  <= pl_mem[pl_ra];
    pos_q <= pos_mem[pos_ra];
  end

  // Free-slot search and live bits.
  scan_ctrl_t scan_ctrl;
  scan_stat_t scan_stat;

  imhq_free_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (scan_ctrl),
    .stat  (scan_stat)
  );

  // The one shared priority comparator.
  logic [PRIO_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt, cmp_eq;

  always_comb begin
    case (state_r)
      S_UP_CMP:  begin cmp_a = q_r;  cmp_b = pr_q;    end
      S_DN_LCMP: begin cmp_a = pr_q; cmp_b = q_r;     end
      S_DN_RCMP: begin cmp_a = pr_q; cmp_b = bprio_r; end
      default:   begin cmp_a = q_r;  cmp_b = pr_q;    end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // Heap arithmetic on the hole position.
  logic [IDX_W-1:0] parent;
  logic [CNT_W:0]   left_w, right_w;

  assign parent  = (p_r - 1'b1) >> 1;
  assign left_w  = {1'b0, p_r, 1'b1};
  assign right_w = left_w + 1'b1;

  logic accept;
  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_req.kind);
      pay_r  <= in_req.payload;
      h_r    <= in_req.handle;
    end
    q_r          <= accept ? in_req.priority_req : q_nxt;
    p_r          <= p_nxt;
    s_r          <= s_nxt;
    ps_r         <= ps_nxt;
    rs_r         <= rs_nxt;
    bsel_r       <= bsel_nxt;
    bidx_r       <= bidx_nxt;
    bslot_r      <= bslot_nxt;
    bprio_r      <= bprio_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_pay_r    <= res_pay_nxt;
    res_prio_r   <= res_prio_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    q_nxt          = q_r;
    p_nxt          = p_r;
    s_nxt          = s_r;
    ps_nxt         = ps_r;
    rs_nxt         = rs_r;
    bsel_nxt       = bsel_r;
    bidx_nxt       = bidx_r;
    bslot_nxt      = bslot_r;
    bprio_nxt      = bprio_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_pay_nxt    = res_pay_r;
    res_prio_nxt   = res_prio_r;

    ho_we = 1'b0;  ho_wa = p_r;   ho_wd = s_r;   ho_ra = '0;
    pr_we = 1'b0;  pr_wa = s_r;   pr_wd = q_r;   pr_ra = '0;
    pl_we = 1'b0;  pl_wa = s_r;                  pl_ra = '0;
    pos_we = 1'b0; pos_wa = s_r;  pos_wd = p_r;  pos_ra = '0;

    scan_ctrl            = '0;
    scan_ctrl.query_slot = h_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = '0;
          res_pay_nxt    = '0;
          res_prio_nxt   = '0;
          state_nxt      = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (kind_r)
          KIND_INSERT: begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_RESULT;
            end else begin
              scan_ctrl.start = 1'b1;
              state_nxt       = S_INS_SCAN;
            end
          end
          KIND_EXTRACT: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_RESULT;
            end else begin
              ho_ra     = '0;
              state_nxt = S_EX_ROOT;
            end
          end
          KIND_UPDATE: begin
            if (!scan_stat.query_live) begin
              res_status_nxt = ST_DEAD;
              state_nxt      = S_RESULT;
            end else begin
              pr_ra     = h_r[IDX_W-1:0];
              pos_ra    = h_r[IDX_W-1:0];
              state_nxt = S_UD_READ;
            end
          end
          default: state_nxt = S_RESULT;
        endcase
      end

      S_INS_SCAN: begin
        if (scan_stat.done) begin
          s_nxt              = scan_stat.slot;
          pl_we              = 1'b1;
          pl_wa              = scan_stat.slot;
          pr_we              = 1'b1;
          pr_wa              = scan_stat.slot;
          scan_ctrl.set_en   = 1'b1;
          scan_ctrl.set_slot = scan_stat.slot;
          p_nxt              = count_r[IDX_W-1:0];
          count_nxt          = count_r + 1'b1;
          res_handle_nxt     = scan_stat.slot;
          state_nxt          = S_UP_CHK;
        end
      end

      S_UP_CHK: begin
        if (p_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          ho_ra     = parent;
          state_nxt = S_UP_SLOT;
        end
      end

      S_UP_SLOT: begin
        ps_nxt    = ho_q;
        pr_ra     = ho_q;
        state_nxt = S_UP_CMP;
      end

      S_UP_CMP: begin
        if (cmp_lt) begin
          // Parent moves down into the hole.
          ho_we     = 1'b1;
          ho_wa     = p_r;
          ho_wd     = ps_r;
          pos_we    = 1'b1;
          pos_wa    = ps_r;
          pos_wd    = p_r;
          p_nxt     = parent;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        ho_we     = 1'b1;
        ho_wa     = p_r;
        ho_wd     = s_r;
        pos_we    = 1'b1;
        pos_wa    = s_r;
        pos_wd    = p_r;
        state_nxt = S_RESULT;
      end

      S_EX_ROOT: begin
        s_nxt     = ho_q;
        pl_ra     = ho_q;
        pr_ra     = ho_q;
        state_nxt = S_EX_DATA;
      end

      S_EX_DATA: begin
        res_handle_nxt     = s_r;
        res_pay_nxt        = pl_q;
        res_prio_nxt       = pr_q;
        scan_ctrl.clr_en   = 1'b1;
        scan_ctrl.clr_slot = s_r;
        count_nxt          = count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_RESULT;
        end else begin
          ho_ra     = count_nxt[IDX_W-1:0];
          state_nxt = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        s_nxt     = ho_q;
        pr_ra     = ho_q;
        state_nxt = S_EX_LPRIO;
      end

      S_EX_LPRIO: begin
        q_nxt     = pr_q;
        p_nxt     = '0;
        state_nxt = S_DN_CHK;
      end

      S_DN_CHK: begin
        if (left_w >= (CNT_W+1)'(count_r)) begin
          state_nxt = S_PLACE;
        end else begin
          ho_ra     = left_w[IDX_W-1:0];
          state_nxt = S_DN_LEFT;
        end
      end

      S_DN_LEFT: begin
        ps_nxt    = ho_q;
        pr_ra     = ho_q;
        ho_ra     = right_w[IDX_W-1:0];
        state_nxt = S_DN_LCMP;
      end

      S_DN_LCMP: begin
        rs_nxt = ho_q;
        if (cmp_lt) begin
          bsel_nxt  = 1'b1;
          bidx_nxt  = left_w[IDX_W-1:0];
          bslot_nxt = ps_r;
          bprio_nxt = pr_q;
        end else begin
          bsel_nxt  = 1'b0;
          bprio_nxt = q_r;
        end
        if (right_w < (CNT_W+1)'(count_r)) begin
          pr_ra     = ho_q;
          state_nxt = S_DN_RCMP;
        end else begin
          state_nxt = S_DN_MOVE;
        end
      end

      S_DN_RCMP: begin
        if (cmp_lt) begin
          bsel_nxt  = 1'b1;
          bidx_nxt  = right_w[IDX_W-1:0];
          bslot_nxt = rs_r;
        end
        state_nxt = S_DN_MOVE;
      end

      S_DN_MOVE: begin
        if (!bsel_r) begin
          state_nxt = S_PLACE;
        end else begin
          // Smaller child moves up into the hole.
          ho_we     = 1'b1;
          ho_wa     = p_r;
          ho_wd     = bslot_r;
          pos_we    = 1'b1;
          pos_wa    = bslot_r;
          pos_wd    = p_r;
          p_nxt     = bidx_r;
          state_nxt = S_DN_CHK;
        end
      end

      S_UD_READ: begin
        p_nxt          = pos_q;
        s_nxt          = h_r[IDX_W-1:0];
        pr_we          = 1'b1;
        pr_wa          = h_r[IDX_W-1:0];
        res_handle_nxt = h_r[IDX_W-1:0];
        if (cmp_lt)      state_nxt = S_UP_CHK;
        else if (cmp_eq) state_nxt = S_RESULT;
        else             state_nxt = S_DN_CHK;
      end

      S_RESULT: begin
        if (out_res.ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_res.valid           = (state_r == S_RESULT);
  assign out_res.status          = res_status_r;
  assign out_res.result_handle   = HANDLE_W'(res_handle_r);
  assign out_res.result_payload  = res_pay_r;
  assign out_res.result_priority = res_prio_r;

  // The entry count can never pass the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A full answer is only given when every slot is taken.
  a_full_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && res_status_r == ST_FULL |-> count_r == CNT_W'(CAPACITY))
    else $error("full reported with free slots");

  // A successful extract removes exactly one entry.
  a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EX_DATA |=> count_r == $past(count_r) - 1'b1)
    else $error("extract did not remove one entry");

  // The free-slot search only runs while an insert waits for it.
  a_scan_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.busy |-> state_r == S_INS_SCAN)
    else $error("slot search outside insert");
endmodule
